// File: design/frame_time_smoother_assert.svh
// ----------------------------------------------------------------------------
// frame_time_smoother_assert.svh
// Assertion macros used by the frame time smoother checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_SMOOTHER_ASSERT_SVH
`define FRAME_TIME_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define FTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/fts_pkg.sv
// ----------------------------------------------------------------------------
// fts_pkg
// Constants, types and control structs of the frame time smoother.
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam int HISTORY_DEPTH = 16;
	localparam int TIME_W = 24;
	localparam int HIST_W = 19;
	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int WIN_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = HIST_W + IDX_W;
	localparam int DIV_W = 25;
	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int ACC_W = 48;
	localparam int HALF_W = 12;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_TIMER_EN = 3'd0;
	localparam logic [2:0] REG_FIXED = 3'd1;
	localparam logic [2:0] REG_MAX = 3'd2;
	localparam logic [2:0] REG_SCALE = 3'd3;
	localparam logic [2:0] REG_SMOOTH = 3'd4;

	localparam logic [TIME_W-1:0] MAX_STEP_RESET = 24'd250000;
	localparam logic [TIME_W-1:0] SCALE_RESET = 24'd65536;
	localparam logic [HIST_W-1:0] HIST_RESET = 19'd33333;
	localparam logic [TIME_W-1:0] AVG_RESET = 24'd33333;
	localparam logic [HIST_W-1:0] CLAMP_TOP = 19'd400000;
	localparam logic [HIST_W-1:0] SHORT_LIMIT = 19'd100;
	localparam logic [DIV_W-1:0] SPAN_X2 = 25'd500000;

	typedef struct packed {
		logic timer_enabled;
		logic [TIME_W-1:0] fixed_step_us;
		logic [TIME_W-1:0] max_step_us;
		logic [TIME_W-1:0] time_scale;
		logic smoothing_on;
	} fts_cfg_t;

	typedef struct packed {
		logic load;
		logic mul_lo;
		logic mul_hi;
		logic scale;
		logic push;
		logic div_start;
		logic div_mean;
		logic win_take;
		logic sum_step;
		logic out_load;
	} fts_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sum_last;
		logic out_free;
	} fts_status_t;

endpackage

// File: design/fts_regs.sv
// ----------------------------------------------------------------------------
// fts_regs
// APB-style configuration registers.
// ----------------------------------------------------------------------------
module fts_regs import fts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output fts_cfg_t          cfg
);

	fts_cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign pready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timer_enabled <= 1'b1;
			cfg_q.fixed_step_us <= '0;
			cfg_q.max_step_us <= MAX_STEP_RESET;
			cfg_q.time_scale <= SCALE_RESET;
			cfg_q.smoothing_on <= 1'b1;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TIMER_EN: cfg_q.timer_enabled <= pwdata[0];
				REG_FIXED:    cfg_q.fixed_step_us <= pwdata[TIME_W-1:0];
				REG_MAX:      cfg_q.max_step_us <= pwdata[TIME_W-1:0];
				REG_SCALE:    cfg_q.time_scale <= pwdata[TIME_W-1:0];
				REG_SMOOTH:   cfg_q.smoothing_on <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_TIMER_EN: prdata = DATA_W'(cfg_q.timer_enabled);
			REG_FIXED:    prdata = DATA_W'(cfg_q.fixed_step_us);
			REG_MAX:      prdata = DATA_W'(cfg_q.max_step_us);
			REG_SCALE:    prdata = DATA_W'(cfg_q.time_scale);
			REG_SMOOTH:   prdata = DATA_W'(cfg_q.smoothing_on);
			default:      prdata = '0;
		endcase
	end

endmodule

// File: design/fts_div.sv
// ----------------------------------------------------------------------------
// fts_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module fts_div import fts_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	output logic [DIV_W-1:0] quot,
	output logic             done
);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q, quo_q, den_q;
	logic [DIV_W:0] trial, diff;
	logic ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff = trial - {1'b0, den_q};
	assign ge = trial >= {1'b0, den_q};
	assign quot = quo_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

endmodule

// File: design/fts_dp.sv
// ----------------------------------------------------------------------------
// fts_dp
// Datapath: step select, split scaling multiply, history, window and mean.
// ----------------------------------------------------------------------------
module fts_dp import fts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  fts_cfg_t          cfg,
	input  fts_cmd_t          cmd,
	output fts_status_t       status,
	input  logic [TIME_W-1:0] real_frame_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TIME_W-1:0] game_frame_us,
	output logic [TIME_W-1:0] real_frame_out_us
);

	logic [TIME_W-1:0] real_q, base_q, fix_abs, scale_mag, base_d;
	logic              neg_q;
	logic [ACC_W-1:0]  acc_q;
	logic [TIME_W+HALF_W-1:0] prod;
	logic [31:0]       mag;
	logic [HIST_W-1:0] c_q;
	logic [TIME_W-1:0] off_q, avg_q, avg;
	logic [HIST_W-1:0] hist_q [HISTORY_DEPTH];
	logic [WIN_W-1:0]  w_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DIV_W-1:0]  div_num, div_den, quot;
	logic              div_done, lzero_q;
	logic              ov_q;
	logic [TIME_W-1:0] game_q, rout_q;

	assign fix_abs = cfg.fixed_step_us[TIME_W-1] ? (~cfg.fixed_step_us + TIME_W'(1))
		: cfg.fixed_step_us;
	assign scale_mag = cfg.time_scale[TIME_W-1] ? (~cfg.time_scale + TIME_W'(1))
		: cfg.time_scale;
	assign base_d = (cfg.fixed_step_us != '0) ? fix_abs
		: ((real_frame_us < cfg.max_step_us) ? real_frame_us : cfg.max_step_us);

	// one 24x12 multiplier, used for the low and then the high half of the scale
	assign prod = base_q * (cmd.mul_hi ? scale_mag[TIME_W-1:HALF_W] : scale_mag[HALF_W-1:0]);
	assign mag = acc_q[ACC_W-1:16];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			real_q <= real_frame_us;
			base_q <= base_d;
			neg_q <= cfg.time_scale[TIME_W-1];
		end
		if (cmd.mul_lo) acc_q <= ACC_W'(prod);
		if (cmd.mul_hi) acc_q <= acc_q + {prod, {HALF_W{1'b0}}};
		if (cmd.scale) begin
			if (neg_q) begin
				c_q <= '0;
				off_q <= '0;
			end else begin
				c_q <= (mag > 32'(CLAMP_TOP)) ? CLAMP_TOP : mag[HIST_W-1:0];
				off_q <= (mag > 32'({TIME_W{1'b1}})) ? {TIME_W{1'b1}} : mag[TIME_W-1:0];
			end
		end
		if (cmd.win_take) begin
			if (lzero_q || quot == '0) w_q <= WIN_W'(1);
			else if (quot > DIV_W'(HISTORY_DEPTH)) w_q <= WIN_W'(HISTORY_DEPTH);
			else w_q <= quot[WIN_W-1:0];
			sum_q <= '0;
			idx_q <= '0;
		end
		if (cmd.sum_step) begin
			sum_q <= sum_q + SUM_W'(hist_q[idx_q]);
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.push) lzero_q <= (avg_q == '0);
		if (cmd.out_load) begin
			game_q <= cfg.smoothing_on ? avg : off_q;
			rout_q <= real_q;
		end
	end

	// history and running average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= HIST_RESET;
			avg_q <= AVG_RESET;
		end else begin
			if (cmd.push) begin
				for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
				hist_q[0] <= c_q;
			end
			if (cmd.out_load && cfg.smoothing_on) avg_q <= avg;
		end
	end

	assign avg = (c_q < SHORT_LIMIT) ? TIME_W'(c_q) : quot[TIME_W-1:0];

	assign div_num = cmd.div_mean ? DIV_W'(sum_q) : (SPAN_X2 + DIV_W'(avg_q));
	assign div_den = cmd.div_mean ? DIV_W'(w_q) : {avg_q, 1'b0};

	fts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (quot),
		.done   (div_done)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (cmd.out_load) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	assign out_valid = ov_q;
	assign game_frame_us = game_q;
	assign real_frame_out_us = rout_q;

	assign status.div_done = div_done;
	assign status.sum_last = ((WIN_W'(idx_q) + WIN_W'(1)) == w_q);
	assign status.out_free = !ov_q || out_ready;

endmodule

// File: design/fts_ctrl.sv
// ----------------------------------------------------------------------------
// fts_ctrl
// Sequencer for one frame: scale, push, window divide, sum, mean divide.
// ----------------------------------------------------------------------------
module fts_ctrl import fts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fts_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	output fts_cmd_t    cmd,
	input  fts_status_t status
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_LO, S_MUL_HI, S_SCALE, S_PUSH,
		S_WDIV, S_SUM, S_MSTART, S_MDIV, S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:   cmd.load = in_valid;
			S_MUL_LO: cmd.mul_lo = 1'b1;
			S_MUL_HI: cmd.mul_hi = 1'b1;
			S_SCALE:  cmd.scale = 1'b1;
			S_PUSH: begin
				cmd.push = 1'b1;
				cmd.div_start = 1'b1;
			end
			S_WDIV:   cmd.win_take = status.div_done;
			S_SUM:    cmd.sum_step = 1'b1;
			S_MSTART: begin
				cmd.div_start = 1'b1;
				cmd.div_mean = 1'b1;
			end
			S_MDIV:   ;
			S_FINISH: cmd.out_load = status.out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:   if (in_valid && cfg.timer_enabled) state_q <= S_MUL_LO;
				S_MUL_LO: state_q <= S_MUL_HI;
				S_MUL_HI: state_q <= S_SCALE;
				S_SCALE:  state_q <= cfg.smoothing_on ? S_PUSH : S_FINISH;
				S_PUSH:   state_q <= S_WDIV;
				S_WDIV:   if (status.div_done) state_q <= S_SUM;
				S_SUM:    if (status.sum_last) state_q <= S_MSTART;
				S_MSTART: state_q <= S_MDIV;
				S_MDIV:   if (status.div_done) state_q <= S_FINISH;
				S_FINISH: if (status.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/frame_time_smoother.sv
// ----------------------------------------------------------------------------
// frame_time_smoother
// Turns measured frame times into scaled, smoothed game frame times.
// ----------------------------------------------------------------------------
// Input channel: one beat per measured frame (real_frame_us), valid/ready.
// Output channel: one beat per accepted frame while the timer is enabled,
//   carrying game_frame_us and the measured time passed through.
// With the timer disabled a beat is taken and dropped; no result or history changes.
// With smoothing off a frame runs the two multiply halves and the scale
//   step; with smoothing on a push with window divide, the window sum
//   (1..16 entries), the mean start and the mean divide follow. The two
//   25-step divides dominate; one frame is in flight at a time.
// The result sits in an output register: a stalled receiver only holds the
//   block in its last step if a second result is ready before the first is
//   taken. The next input beat is taken as soon as the result is registered.
// Reset: registers go to their defaults, every history entry and the last
//   average to 33333 us, no output beat pending.
// Configuration is written over the APB-style port; the user must do so
//   only while the block is idle. The block itself does not enforce this.
// ----------------------------------------------------------------------------
module frame_time_smoother import fts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] real_frame_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TIME_W-1:0] game_frame_us,
	output logic [TIME_W-1:0] real_frame_out_us
);

	fts_cfg_t    cfg;
	fts_cmd_t    cmd;
	fts_status_t status;

	// register file
	fts_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: in_ready is high only between frames
	fts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath with shared divider and output register
	fts_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg),
		.cmd               (cmd),
		.status            (status),
		.real_frame_us     (real_frame_us),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.game_frame_us     (game_frame_us),
		.real_frame_out_us (real_frame_out_us)
	);

endmodule

// File: design/fts_checker.sv
// ----------------------------------------------------------------------------
// fts_checker
// Port-level checks on the frame time smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_time_smoother_assert.svh"

module fts_checker import fts_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TIME_W-1:0] game_frame_us,
	input logic [TIME_W-1:0] real_frame_out_us
);

	`FTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "output beat dropped")

	`FTS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(game_frame_us) && $stable(real_frame_out_us), "stalled output changed")

	`FTS_ASSERT_NOW(a_load_busy, $rose(out_valid), !$past(in_ready), "result loaded while idle")

	`FTS_ASSERT_NOW(a_busy_taken, $fell(in_ready), $past(in_valid), "busy without input beat")

endmodule

bind frame_time_smoother fts_checker u_fts_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_ready          (in_ready),
	.out_valid         (out_valid),
	.out_ready         (out_ready),
	.game_frame_us     (game_frame_us),
	.real_frame_out_us (real_frame_out_us)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the frame time smoother: APB setup, random input
// and output handshakes, and a predictor of the scaled, smoothed frame time.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class frame_scoreboard;
	// predictor copy of registers and state
	bit        timer_enabled;
	bit [23:0] fixed_step_us;
	bit [23:0] max_step_us;
	bit [23:0] time_scale;
	bit        smoothing_on;
	bit [18:0] history [16];
	bit [23:0] last_average;
	bit [23:0] game_q [$];
	bit [23:0] real_q [$];
	int        errors;

	function new();
		timer_enabled = 1;
		fixed_step_us = 0;
		max_step_us = 24'd250000;
		time_scale = 24'd65536;
		smoothing_on = 1;
		foreach (history[i]) history[i] = 19'd33333;
		last_average = 24'd33333;
		errors = 0;
	endfunction

	function void write_reg(int idx, bit [31:0] v);
		case (idx)
			0: timer_enabled = v[0];
			1: fixed_step_us = v[23:0];
			2: max_step_us = v[23:0];
			3: time_scale = v[23:0];
			4: smoothing_on = v[0];
			default: ;
		endcase
	endfunction

	// note an accepted input beat and work out its result
	function void note_frame(bit [23:0] real_us);
		longint base, s, mag, scaled, sum, l, w, avg, c;
		bit [23:0] game;
		if (!timer_enabled)
			return;
		if (fixed_step_us != 0) begin
			s = longint'($signed(fixed_step_us));
			base = s < 0 ? -s : s;
		end else
			base = real_us < max_step_us ? real_us : max_step_us;
		s = longint'($signed(time_scale));
		mag = s < 0 ? -s : s;
		scaled = (base * mag) >>> 16;
		if (s < 0)
			scaled = -scaled;
		if (smoothing_on) begin
			c = scaled > 400000 ? 400000 : (scaled < 0 ? 0 : scaled);
			for (int i = 15; i > 0; i--)
				history[i] = history[i-1];
			history[0] = c[18:0];
			if (last_average == 0)
				w = 1;
			else begin
				l = last_average;
				w = (500000 + l) / (2 * l);
				if (w > 16) w = 16;
				if (w < 1) w = 1;
			end
			sum = 0;
			for (int i = 0; i < w; i++)
				sum += history[i];
			avg = sum / w;
			if (c < 100)
				avg = c;
			last_average = avg[23:0];
			game = avg[23:0];
		end else if (scaled < 0)
			game = 0;
		else if (scaled > 24'hFFFFFF)
			game = 24'hFFFFFF;
		else
			game = scaled[23:0];
		game_q.push_back(game);
		real_q.push_back(real_us);
	endfunction

	function void check_result(bit [23:0] game, bit [23:0] real_us);
		bit [23:0] eg, er;
		if (game_q.size() == 0) begin
			$display("%0t: unexpected result game %0d real %0d", $time, game, real_us);
			errors++;
			return;
		end
		eg = game_q.pop_front();
		er = real_q.pop_front();
		if (eg !== game) begin
			$display("%0t: game_frame_us expected %0d actual %0d", $time, eg, game);
			errors++;
		end
		if (er !== real_us) begin
			$display("%0t: real_frame_out_us expected %0d actual %0d", $time, er, real_us);
			errors++;
		end
	endfunction
endclass

module testbench;
	import fts_pkg::*;

	logic              clk = 0;
	logic              arst_n = 0;
	logic              psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid = 0;
	logic              in_ready;
	logic [TIME_W-1:0] real_frame_us = '0;
	logic              out_valid;
	logic              out_ready = 0;
	logic [TIME_W-1:0] game_frame_us, real_frame_out_us;

	frame_scoreboard sb = new();
	int send_idle = 0;   // percent of cycles the sender idles
	int recv_stall = 0;  // percent of cycles the receiver stalls
	bit hold_off = 0;    // long receiver hold-off in progress

	frame_time_smoother i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stalls, or a long hold-off while hold_off is set
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(game_frame_us, real_frame_out_us);
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	// one register write: setup then access beat
	task automatic write_reg(int idx, bit [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= ADDR_W'(4 * idx); pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		sb.write_reg(idx, v);
	endtask

	// one input beat, with random idle cycles in front
	task automatic send_frame(bit [23:0] v);
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_valid <= 1;
		real_frame_us <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_frame(v);
		in_valid <= 0;
	endtask

	// wait until every result is in, then let the block settle
	task automatic drain();
		int n;
		n = 0;
		while (sb.game_q.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
	endtask

	function automatic bit [23:0] rand_time();
		case ($urandom_range(5))
			0: return 24'($urandom_range(150));
			1: return 24'($urandom_range(60000, 5000));
			2: return 24'($urandom_range(450000));
			3: return 24'($urandom);
			default: return 24'($urandom_range(40000, 10000));
		endcase
	endfunction

	function automatic bit [31:0] rand_scale();
		case ($urandom_range(4))
			0: return 32'd65536;
			1: return $urandom_range(200000);
			2: return 32'h00FF0000 | $urandom_range(65535);  // negative
			3: return $urandom;
			default: return $urandom_range(131072, 16384);
		endcase
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: field extremes, short times, fixed steps, scale corners
		send_frame(0);
		send_frame(24'hFFFFFF);
		send_frame(99);
		send_frame(100);
		send_frame(33333);
		send_frame(250000);
		send_frame(24'h555555);
		send_frame(24'hAAAAAA);
		drain();
		write_reg(1, 32'h00800000);    // most negative fixed step
		write_reg(3, 32'h007FFFFF);    // largest scale
		send_frame(1);
		send_frame(5);
		drain();
		write_reg(4, 0);               // smoothing off, saturation
		send_frame(7);
		drain();
		write_reg(3, 32'h00800000);    // most negative scale
		send_frame(1000);
		drain();
		write_reg(1, 32'h007FFFFF);
		write_reg(3, 0);
		write_reg(4, 1);
		send_frame(20);                // clamped time zero, average zero
		send_frame(20);
		drain();
		write_reg(1, 0);
		write_reg(2, 32'h00FFFFFF);
		write_reg(3, 32'd65536);
		write_reg(0, 0);               // timer off: beats dropped
		send_frame(1234);
		send_frame(24'hFFFFFF);
		repeat (100) @(posedge clk);
		write_reg(0, 1);
		write_reg(2, 0);
		send_frame(5000);
		drain();
		write_reg(2, 32'd250000);
		send_frame(500000);
		drain();

		// random phases with varying configuration and idling
		for (int ph = 0; ph < 14; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 87; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 87; end
				default: begin send_idle = 19; recv_stall = 19; end
			endcase
			write_reg(0, ($urandom_range(9) != 0));
			write_reg(1, ($urandom_range(3) == 0) ? $urandom : 0);
			write_reg(2, ($urandom_range(2) == 0) ? $urandom : 250000);
			write_reg(3, rand_scale());
			write_reg(4, ($urandom_range(4) != 0));
			if (ph == 5) begin
				// receiver holds off for a long stretch while beats queue up
				fork
					begin
						hold_off = 1;
						repeat (600) @(posedge clk);
						hold_off = 0;
					end
					for (int k = 0; k < 20; k++) send_frame(rand_time());
				join
			end
			for (int k = 0; k < 100; k++)
				send_frame(rand_time());
			drain();
		end

		if (sb.errors == 0 && sb.game_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
